>>> hw/rtl/mi4_pkg.sv
package mi4_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W = 128;
    localparam int MANT_W = 56;
    localparam int SH_W = 7;
    localparam int DIV_LAST = MANT_W - 1;
    localparam int NUM_MINORS = 12;

    typedef enum logic [10:0] {
        S_LOAD = 11'b00000000001,
        S_RDA  = 11'b00000000010,
        S_RDB  = 11'b00000000100,
        S_LATB = 11'b00000001000,
        S_MUL  = 11'b00000010000,
        S_MACC = 11'b00000100000,
        S_NEXT = 11'b00001000000,
        S_MINW = 11'b00010000000,
        S_NORM = 11'b00100000000,
        S_DIV  = 11'b01000000000,
        S_COFW = 11'b10000000000
    } t_state;

    typedef enum logic [2:0] {
        PH_MINOR,
        PH_DET,
        PH_COF,
        PH_OUT,
        PH_EMIT
    } t_phase;

    typedef enum logic {
        SRC_ELEM,
        SRC_MINOR
    } t_src;

    localparam logic [3:0] MINOR_IDX [12][4] = '{
        '{4'd0, 4'd5, 4'd4, 4'd1},   '{4'd0, 4'd6, 4'd4, 4'd2},
        '{4'd0, 4'd7, 4'd4, 4'd3},   '{4'd1, 4'd6, 4'd5, 4'd2},
        '{4'd1, 4'd7, 4'd5, 4'd3},   '{4'd2, 4'd7, 4'd6, 4'd3},
        '{4'd8, 4'd13, 4'd12, 4'd9}, '{4'd8, 4'd14, 4'd12, 4'd10},
        '{4'd8, 4'd15, 4'd12, 4'd11}, '{4'd9, 4'd14, 4'd13, 4'd10},
        '{4'd9, 4'd15, 4'd13, 4'd11}, '{4'd10, 4'd15, 4'd14, 4'd11}
    };

    localparam logic [3:0] COF_E [16][3] = '{
        '{4'd5, 4'd6, 4'd7},    '{4'd1, 4'd2, 4'd3},
        '{4'd13, 4'd14, 4'd15}, '{4'd9, 4'd10, 4'd11},
        '{4'd4, 4'd6, 4'd7},    '{4'd0, 4'd2, 4'd3},
        '{4'd12, 4'd14, 4'd15}, '{4'd8, 4'd10, 4'd11},
        '{4'd4, 4'd5, 4'd7},    '{4'd0, 4'd1, 4'd3},
        '{4'd12, 4'd13, 4'd15}, '{4'd8, 4'd9, 4'd11},
        '{4'd4, 4'd5, 4'd6},    '{4'd0, 4'd1, 4'd2},
        '{4'd12, 4'd13, 4'd14}, '{4'd8, 4'd9, 4'd10}
    };

    localparam logic [3:0] COF_M [16][3] = '{
        '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd10, 4'd9},
        '{4'd5, 4'd4, 4'd3},   '{4'd5, 4'd4, 4'd3},
        '{4'd11, 4'd8, 4'd7},  '{4'd11, 4'd8, 4'd7},
        '{4'd5, 4'd2, 4'd1},   '{4'd5, 4'd2, 4'd1},
        '{4'd10, 4'd8, 4'd6},  '{4'd10, 4'd8, 4'd6},
        '{4'd4, 4'd2, 4'd0},   '{4'd4, 4'd2, 4'd0},
        '{4'd9, 4'd7, 4'd6},   '{4'd9, 4'd7, 4'd6},
        '{4'd3, 4'd1, 4'd0},   '{4'd3, 4'd1, 4'd0}
    };

    localparam logic [2:0] COF_S [16] = '{
        3'b010, 3'b101, 3'b010, 3'b101,
        3'b101, 3'b010, 3'b101, 3'b010,
        3'b010, 3'b101, 3'b010, 3'b101,
        3'b101, 3'b010, 3'b101, 3'b010
    };

    function automatic logic [63:0] sat64(input logic [ACC_W-1:0] x);
        logic [63:0] r;
        if ((&x[ACC_W-1:63]) || !(|x[ACC_W-1:63])) begin
            r = x[63:0];
        end else if (x[ACC_W-1]) begin
            r = {1'b1, 63'b0};
        end else begin
            r = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic [ACC_W-1:0] x);
        logic [31:0] r;
        if ((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31])) begin
            r = x[31:0];
        end else if (x[ACC_W-1]) begin
            r = {1'b1, 31'b0};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

>>> hw/rtl/mi4_limb_mul.sv
module mi4_limb_mul
    import mi4_pkg::*;
(
    input  logic        i_clk,
    input  logic [63:0] i_ma,
    input  logic [63:0] i_mb,
    input  logic [1:0]  i_limb,
    output logic [63:0] o_prod
);

    logic [31:0] a_l;
    logic [31:0] b_l;
    logic [63:0] r_prod;

    assign a_l = i_limb[0] ? i_ma[63:32] : i_ma[31:0];
    assign b_l = i_limb[1] ? i_mb[63:32] : i_mb[31:0];

    always_ff @(posedge i_clk) begin
        r_prod <= a_l * b_l;
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/matrix4_inverse_top.sv
// 4x4 matrix inverse in signed fixed point by the cofactor method.
// Requests carry one matrix element each, in row-major order, and are taken
// on a rising edge with i_start high and o_busy low. The first fifteen
// requests only store their element, one per cycle, and o_busy stays low.
// The sixteenth starts the computation and raises o_busy until the last
// inverse element has been sent.
// All products go through one 32x32 multiplier that is fed 32-bit limbs.
// The sequencer forms the twelve 2x2 minors, then the determinant, then
// scans the determinant for its leading one and runs the restoring divider
// for its reciprocal, and then forms each of the sixteen results from a
// cofactor. A zero determinant skips the scan and the divider.
// Each result is shown for one cycle with o_result_strobe high; the
// receiver cannot stall it. o_last_element marks the sixteenth result and
// o_singular marks a zero determinant, for which all results are zero.
// Reset clears the element counter and the sequencer and returns the block
// to accepting elements.
module matrix4_inverse_top
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_element_value,
    output logic        o_busy,
    output logic        o_result_strobe,
    output logic [31:0] o_inverse_value,
    output logic        o_last_element,
    output logic        o_singular
);

    t_state r_state;
    t_phase r_phase;
    logic [3:0]  r_load;
    logic [3:0]  r_k;
    logic [2:0]  r_t;
    logic [1:0]  r_limb;
    logic [1:0]  r_plimb;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_d;
    logic [6:0]  r_p;
    logic [MANT_W-1:0] r_q;
    logic [5:0]  r_cnt;
    logic [63:0] r_ma;
    logic [63:0] r_mb;
    logic        r_asgn;
    logic        r_pneg;
    logic [MANT_W-1:0] r_mant;
    logic [SH_W-1:0]   r_sh;
    logic        r_dneg;
    logic        r_strobe;
    logic [31:0] r_out;
    logic        r_last;
    logic        r_sing;

    logic [31:0] r_elem [16];
    logic [31:0] r_erd;
    logic [63:0] r_minor [NUM_MINORS];
    logic [63:0] r_mrd;

    t_src        a_src;
    t_src        b_src;
    logic [3:0]  a_addr;
    logic [3:0]  b_addr;
    logic        sub;
    logic [3:0]  rd_addr;
    logic [3:0]  m_addr;
    logic [63:0] prod;
    logic [ACC_W-1:0] prod_ext;
    logic [ACC_W-1:0] acc_add;
    logic [ACC_W-1:0] acc_frac;
    logic [ACC_W-1:0] acc_out;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] cof;
    logic        div_ge;
    logic [ACC_W-1:0] div_rem;
    logic [SH_W-1:0]  sh_clamp;
    int          sh_sum;

    always_comb begin
        a_src  = SRC_ELEM;
        b_src  = SRC_ELEM;
        a_addr = 4'd0;
        b_addr = 4'd0;
        sub    = 1'b0;
        case (r_phase)
            PH_MINOR: begin
                a_addr = MINOR_IDX[r_k][{r_t[0], 1'b0}];
                b_addr = MINOR_IDX[r_k][{r_t[0], 1'b1}];
                sub    = r_t[0];
            end
            PH_DET: begin
                a_src  = SRC_MINOR;
                b_src  = SRC_MINOR;
                a_addr = {1'b0, r_t};
                b_addr = 4'd11 - {1'b0, r_t};
                sub    = (r_t == 3'd1) || (r_t == 3'd4);
            end
            PH_COF: begin
                b_src  = SRC_MINOR;
                a_addr = COF_E[r_k][r_t[1:0]];
                b_addr = COF_M[r_k][r_t[1:0]];
                sub    = COF_S[r_k][r_t[1:0]];
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = (r_state == S_RDA) ? a_addr : b_addr;
    assign m_addr  = (rd_addr < 4'(NUM_MINORS)) ? rd_addr : 4'd0;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && i_start) begin
            r_elem[r_load] <= i_element_value;
        end
        r_erd <= r_elem[rd_addr];
        if (r_state == S_MINW) begin
            r_minor[r_k] <= sat64(acc_frac);
        end
        r_mrd <= r_minor[m_addr];
    end

    mi4_limb_mul u_mul (
        .i_clk  (i_clk),
        .i_ma   (r_ma),
        .i_mb   (r_mb),
        .i_limb (r_limb),
        .o_prod (prod)
    );

    always_comb begin
        case (r_plimb)
            2'd0:    prod_ext = {64'b0, prod};
            2'd3:    prod_ext = {prod, 64'b0};
            default: prod_ext = {32'b0, prod, 32'b0};
        endcase
    end

    assign acc_add  = r_pneg ? (r_acc - prod_ext) : (r_acc + prod_ext);
    assign acc_frac = $signed(r_acc) >>> FRAC_BITS;
    assign acc_out  = $signed(r_acc) >>> r_sh;
    assign op_a     = (a_src == SRC_ELEM) ? {{32{r_erd[31]}}, r_erd} : r_mrd;
    assign op_b     = (b_src == SRC_ELEM) ? {{32{r_erd[31]}}, r_erd} : r_mrd;
    assign cof      = sat64(acc_frac);
    assign div_ge   = (r_acc >= r_d);
    assign div_rem  = div_ge ? (r_acc - r_d) : r_acc;

    always_comb begin
        sh_sum = int'(r_p) + MANT_W - 1 - 2 * FRAC_BITS;
        if (sh_sum < 0) begin
            sh_clamp = '0;
        end else if (sh_sum > 127) begin
            sh_clamp = '1;
        end else begin
            sh_clamp = sh_sum[SH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_phase <= PH_MINOR;
            r_load  <= '0;
            r_mant  <= '0;
            r_sh    <= '0;
            r_dneg  <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_start) begin
                        r_load <= r_load + 4'd1;
                        if (r_load == 4'd15) begin
                            r_state <= S_RDA;
                            r_phase <= PH_MINOR;
                            r_k     <= '0;
                            r_t     <= '0;
                            r_acc   <= '0;
                        end
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_asgn  <= op_a[63];
                    r_ma    <= mag64(op_a);
                    r_state <= S_LATB;
                end
                S_LATB: begin
                    r_mb    <= mag64(op_b);
                    r_pneg  <= r_asgn ^ op_b[63] ^ sub;
                    r_limb  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_plimb <= r_limb;
                    r_limb  <= r_limb + 2'd1;
                    if (r_limb != 2'd0) begin
                        r_acc <= acc_add;
                    end
                    if (r_limb == 2'd3) begin
                        r_state <= S_MACC;
                    end
                end
                S_MACC: begin
                    r_acc   <= acc_add;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    case (r_phase)
                        PH_MINOR: begin
                            if (r_t == 3'd0) begin
                                r_t     <= 3'd1;
                                r_state <= S_RDA;
                            end else begin
                                r_state <= S_MINW;
                            end
                        end
                        PH_DET: begin
                            if (r_t == 3'd5) begin
                                if (r_acc == '0) begin
                                    r_mant  <= '0;
                                    r_sh    <= '0;
                                    r_dneg  <= 1'b0;
                                    r_phase <= PH_COF;
                                    r_k     <= '0;
                                    r_t     <= '0;
                                    r_state <= S_RDA;
                                end else begin
                                    r_d     <= r_acc[ACC_W-1] ? ('0 - r_acc) : r_acc;
                                    r_dneg  <= r_acc[ACC_W-1];
                                    r_p     <= '1;
                                    r_state <= S_NORM;
                                end
                            end else begin
                                r_t     <= r_t + 3'd1;
                                r_state <= S_RDA;
                            end
                        end
                        PH_COF: begin
                            if (r_t == 3'd2) begin
                                r_state <= S_COFW;
                            end else begin
                                r_t     <= r_t + 3'd1;
                                r_state <= S_RDA;
                            end
                        end
                        default: begin
                            r_strobe <= 1'b1;
                            r_out    <= sat32(acc_out);
                            r_last   <= (r_k == 4'd15);
                            r_sing   <= (r_mant == '0);
                            r_acc    <= '0;
                            r_t      <= '0;
                            r_phase  <= PH_COF;
                            r_k      <= r_k + 4'd1;
                            r_state  <= (r_k == 4'd15) ? S_LOAD : S_RDA;
                        end
                    endcase
                end
                S_MINW: begin
                    r_acc   <= '0;
                    r_t     <= '0;
                    r_state <= S_RDA;
                    if (r_k == 4'(NUM_MINORS - 1)) begin
                        r_phase <= PH_DET;
                        r_k     <= '0;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_NORM: begin
                    if (r_d[r_p]) begin
                        r_acc   <= {{(ACC_W-1){1'b0}}, 1'b1} << r_p;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_p <= r_p - 7'd1;
                    end
                end
                S_DIV: begin
                    r_acc <= {div_rem[ACC_W-2:0], 1'b0};
                    r_q   <= {r_q[MANT_W-2:0], div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_LAST)) begin
                        r_mant  <= {r_q[MANT_W-2:0], div_ge};
                        r_sh    <= sh_clamp;
                        r_phase <= PH_COF;
                        r_k     <= '0;
                        r_t     <= '0;
                        r_acc   <= '0;
                        r_state <= S_RDA;
                    end
                end
                S_COFW: begin
                    r_ma    <= mag64(cof);
                    r_mb    <= {{(64-MANT_W){1'b0}}, r_mant};
                    r_pneg  <= cof[63] ^ r_dneg;
                    r_acc   <= '0;
                    r_limb  <= '0;
                    r_phase <= PH_OUT;
                    r_state <= S_MUL;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_busy          = (r_state != S_LOAD);
    assign o_result_strobe = r_strobe;
    assign o_inverse_value = r_out;
    assign o_last_element  = r_last;
    assign o_singular      = r_sing;

endmodule

>>> hw/rtl/mi4_checker.sv
module mi4_checker
    import mi4_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_busy,
    input logic        i_strobe,
    input logic [31:0] i_value,
    input logic        i_last,
    input logic        i_sing
);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && !i_last |-> i_busy)
        else $error("result sent while idle");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && i_sing |-> i_value == 32'd0)
        else $error("singular result is not zero");

    a_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe |=> !i_strobe)
        else $error("results in consecutive cycles");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && i_last |-> !i_busy)
        else $error("still busy after the last result");

endmodule

bind matrix4_inverse_top mi4_checker u_mi4_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_busy   (o_busy),
    .i_strobe (o_result_strobe),
    .i_value  (o_inverse_value),
    .i_last   (o_last_element),
    .i_sing   (o_singular)
);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import mi4_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        singular;
    } t_inverse_elem;

    // Element pairs a,d,b,c of each 2x2 minor: a*d - b*c.
    localparam int MINOR_TERMS [12][4] = '{
        '{0, 5, 4, 1}, '{0, 6, 4, 2}, '{0, 7, 4, 3}, '{1, 6, 5, 2},
        '{1, 7, 5, 3}, '{2, 7, 6, 3}, '{8, 13, 12, 9}, '{8, 14, 12, 10},
        '{8, 15, 12, 11}, '{9, 14, 13, 10}, '{9, 15, 13, 11}, '{10, 15, 14, 11}
    };

    // For each output: element index, minor index and subtract flag of three terms.
    localparam int ADJ_TERMS [16][3][3] = '{
        '{'{5, 11, 0}, '{6, 10, 1}, '{7, 9, 0}},  '{'{1, 11, 1}, '{2, 10, 0}, '{3, 9, 1}},
        '{'{13, 5, 0}, '{14, 4, 1}, '{15, 3, 0}}, '{'{9, 5, 1}, '{10, 4, 0}, '{11, 3, 1}},
        '{'{4, 11, 1}, '{6, 8, 0}, '{7, 7, 1}},   '{'{0, 11, 0}, '{2, 8, 1}, '{3, 7, 0}},
        '{'{12, 5, 1}, '{14, 2, 0}, '{15, 1, 1}}, '{'{8, 5, 0}, '{10, 2, 1}, '{11, 1, 0}},
        '{'{4, 10, 0}, '{5, 8, 1}, '{7, 6, 0}},   '{'{0, 10, 1}, '{1, 8, 0}, '{3, 6, 1}},
        '{'{12, 4, 0}, '{13, 2, 1}, '{15, 0, 0}}, '{'{8, 4, 1}, '{9, 2, 0}, '{11, 0, 1}},
        '{'{4, 9, 1}, '{5, 7, 0}, '{6, 6, 1}},    '{'{0, 9, 0}, '{1, 7, 1}, '{2, 6, 0}},
        '{'{12, 3, 1}, '{13, 1, 0}, '{14, 0, 1}}, '{'{8, 3, 0}, '{9, 1, 1}, '{10, 0, 0}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [31:0] i_element_value;
    logic        o_busy;
    logic        o_result_strobe;
    logic [31:0] o_inverse_value;
    logic        o_last_element;
    logic        o_singular;

    logic signed [31:0] element_mem [16];
    logic signed [63:0] minor_mem [12];
    int                 load_idx;
    t_inverse_elem      expected_inverse [$];
    int                 error_count;

    matrix4_inverse_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_element_value(i_element_value),
        .o_busy(o_busy),
        .o_result_strobe(o_result_strobe),
        .o_inverse_value(o_inverse_value),
        .o_last_element(o_last_element),
        .o_singular(o_singular)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] clamp64(input logic signed [127:0] x);
        if (x > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (x < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return x[63:0];
    endfunction

    task automatic compute_inverse();
        logic signed [127:0] det, d, acc, term, prod;
        logic [191:0]        numer;
        logic [55:0]         mant;
        logic signed [63:0]  cof;
        logic signed [31:0]  res;
        int                  msb, sh;
        logic                neg;
        t_inverse_elem       item;
        for (int k = 0; k < 12; k++) begin
            acc = 128'(element_mem[MINOR_TERMS[k][0]]) * 128'(element_mem[MINOR_TERMS[k][1]])
                - 128'(element_mem[MINOR_TERMS[k][2]]) * 128'(element_mem[MINOR_TERMS[k][3]]);
            minor_mem[k] = clamp64(acc >>> FB);
        end
        det = 128'(minor_mem[0]) * 128'(minor_mem[11]) - 128'(minor_mem[1]) * 128'(minor_mem[10])
            + 128'(minor_mem[2]) * 128'(minor_mem[9]) + 128'(minor_mem[3]) * 128'(minor_mem[8])
            - 128'(minor_mem[4]) * 128'(minor_mem[7]) + 128'(minor_mem[5]) * 128'(minor_mem[6]);
        neg = det < 0;
        d = neg ? -det : det;
        mant = '0;
        sh = 0;
        if (det != 0) begin
            msb = 0;
            for (int i = 0; i < 128; i++) if (d[i]) msb = i;
            numer = 192'd1 << (msb + 55);
            mant = 56'(numer / {64'd0, d});
            sh = msb + 55 - 2 * FB;
            if (sh < 0) sh = 0;
            if (sh > 127) sh = 127;
        end
        for (int k = 0; k < 16; k++) begin
            acc = '0;
            for (int t = 0; t < 3; t++) begin
                term = 128'(element_mem[ADJ_TERMS[k][t][0]]) * 128'(minor_mem[ADJ_TERMS[k][t][1]]);
                acc = ADJ_TERMS[k][t][2] ? acc - term : acc + term;
            end
            cof = clamp64(acc >>> FB);
            prod = 128'(cof) * $signed({72'd0, mant});
            if (neg) prod = -prod;
            prod = prod >>> sh;
            if (prod > 128'sh7FFF_FFFF) res = 32'sh7FFF_FFFF;
            else if (prod < -128'sh8000_0000) res = 32'sh8000_0000;
            else res = prod[31:0];
            item.value = res;
            item.last = (k == 15);
            item.singular = (mant == 0);
            expected_inverse.push_back(item);
        end
    endtask

    // The task, not its caller, holds i_start high between back-to-back requests; a random gap may lower it first.
    task automatic send_element(input logic [31:0] value);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_element_value = value;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        element_mem[load_idx] = value;
        if (load_idx == 15) begin
            load_idx = 0;
            compute_inverse();
        end else begin
            load_idx++;
        end
    endtask

    task automatic send_matrix(input logic [31:0] m [16]);
        for (int i = 0; i < 16; i++) send_element(m[i]);
    endtask

    task automatic test_identity();
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
        send_matrix(m);
    endtask

    task automatic test_singular();
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = 32'h0;
        send_matrix(m);
    endtask

    task automatic test_extremes();
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = 32'h0;
        m[0] = 32'h8000_0000;
        m[5] = 32'h7FFF_FFFF;
        m[10] = 32'h8000_0000;
        m[15] = 32'h7FFF_FFFF;
        m[3] = 32'hFFFF_FFFF;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0000_0001 : 32'h0;
        send_matrix(m);
    endtask

    task automatic test_random(input int count);
        logic [31:0] m [16];
        int          kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 4);
            for (int i = 0; i < 16; i++) begin
                case (kind)
                    0: m[i] = $urandom;
                    1: m[i] = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
                    2: m[i] = (i >= 12) ? m[i - 4] : 32'($signed($urandom_range(0, 32'h4_0000))
                              - 32'sh2_0000);
                    3: m[i] = (i % 5 == 0) ? 32'h0001_0000 + ($urandom & 32'h000F_FFFF)
                              : 32'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
                    default: m[i] = 32'($signed($urandom_range(0, 512)) - 256);
                endcase
            end
            send_matrix(m);
        end
    endtask

    always @(posedge i_clk) begin
        t_inverse_elem want;
        if (i_rst_n && o_result_strobe) begin
            if (expected_inverse.size() == 0) begin
                $display("%0t: unexpected result value %h", $time, o_inverse_value);
                error_count++;
            end else begin
                want = expected_inverse.pop_front();
                if (o_inverse_value !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value,
                             o_inverse_value);
                    error_count++;
                end
                if (o_last_element !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last,
                             o_last_element);
                    error_count++;
                end
                if (o_singular !== want.singular) begin
                    $display("%0t: singular expected %b actual %b", $time, want.singular,
                             o_singular);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        error_count = 0;
        load_idx = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_element_value = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_identity();
        test_singular();
        test_extremes();
        test_random(22);
        @(negedge i_clk);
        i_start = 1'b0;
        while (expected_inverse.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (error_count == 0 && expected_inverse.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
